@@ src/hue_cycle_hsv_to_rgb_macros.svh @@
// Assertion macros shared by the hue cycle HSV to RGB modules.
`ifndef HUE_CYCLE_HSV_TO_RGB_MACROS_SVH
`define HUE_CYCLE_HSV_TO_RGB_MACROS_SVH
`ifndef SYNTHESIS
`define HCHR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HCHR_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HCHR_ASSERT(label, prop, msg)
`define HCHR_NEVER(label, expr, msg)
`endif
`endif

@@ src/hchr_pkg.sv @@
// Shared constants, types and helper functions of the hue cycle HSV to RGB block.
package hchr_pkg;

	localparam int HUE_BITS   = 16;
	localparam int COLOR_BITS = 8;
	localparam int ELAPSED_W  = 16;
	localparam int SPEED_W    = 24;
	localparam int OFFSET_W   = 16;
	localparam int UNIT_W     = 8;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int FIFO_DEPTH = 2;

	localparam int UP_SHIFT   = (HUE_BITS >= 16) ? HUE_BITS - 16 : 0;
	localparam int DOWN_SHIFT = (HUE_BITS < 16) ? 16 - HUE_BITS : 0;

	localparam logic [SPEED_W-1:0]  SPEED_RESET      = 24'd5243;
	localparam logic [OFFSET_W-1:0] HUE_OFFSET_RESET = 16'd0;
	localparam logic [UNIT_W-1:0]   SATURATION_RESET = 8'd230;
	localparam logic [UNIT_W-1:0]   BRIGHTNESS_RESET = 8'd242;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 8'd3;

	typedef logic [HUE_BITS-1:0] hue_t;

	typedef struct packed {
		logic [UNIT_W-1:0] saturation;
		logic [UNIT_W-1:0] brightness;
	} color_cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [15:0]       hue;
	} result_t;

	function automatic hue_t q16_to_hue(input logic [15:0] x);
		logic [47:0] wide;
		wide = (48'(x) << UP_SHIFT) >> DOWN_SHIFT;
		return hue_t'(wide);
	endfunction

	function automatic logic [15:0] hue_to_q16(input hue_t h);
		logic [47:0] wide;
		wide = (48'(h) << DOWN_SHIFT) >> UP_SHIFT;
		return wide[15:0];
	endfunction

endpackage

@@ src/hchr_fifo.sv @@
// Short hue queue between the phase front end and the color back end.
`include "hue_cycle_hsv_to_rgb_macros.svh"

module hchr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hchr_pkg::hue_t    data_in,
	output logic              full,
	input  logic              pop,
	output hchr_pkg::hue_t    data_out,
	output logic              empty
);

	localparam int PTR_W = (hchr_pkg::FIFO_DEPTH > 1) ? $clog2(hchr_pkg::FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(hchr_pkg::FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(hchr_pkg::FIFO_DEPTH - 1);

	hchr_pkg::hue_t   mem_q [hchr_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(hchr_pkg::FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign data_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	`HCHR_NEVER(a_fifo_overflow, push && full, "Hue queue written while full.")
	`HCHR_NEVER(a_fifo_underflow, pop && empty, "Hue queue read while empty.")
	`HCHR_ASSERT(a_fifo_count, push && !pop |=> cnt_q == $past(cnt_q) + 1'b1, "Hue queue count did not grow on a write.")

endmodule

@@ src/hchr_front.sv @@
// Front end: takes time ticks, advances the hue phase and queues the hue of each tick.
module hchr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [hchr_pkg::ELAPSED_W-1:0]  elapsed,
	output logic                            full,
	input  logic [hchr_pkg::SPEED_W-1:0]    speed,
	input  logic [hchr_pkg::OFFSET_W-1:0]   hue_offset,
	output logic                            fifo_push,
	output hchr_pkg::hue_t                  fifo_data,
	input  logic                            fifo_full
);

	localparam int PROD_W = hchr_pkg::ELAPSED_W + hchr_pkg::SPEED_W;

	logic [PROD_W-1:0] prod;
	hchr_pkg::hue_t    inc;
	hchr_pkg::hue_t    phase_next;
	hchr_pkg::hue_t    phase_q;
	hchr_pkg::hue_t    inc_s1;
	logic              valid_s1;

	assign prod       = PROD_W'(elapsed) * PROD_W'(speed);
	assign inc        = hchr_pkg::hue_t'(prod >> (32 - hchr_pkg::HUE_BITS));
	assign phase_next = phase_q + inc_s1;
	assign fifo_data  = phase_next + hchr_pkg::q16_to_hue(hue_offset);
	assign fifo_push  = valid_s1 && !fifo_full;
	assign full       = valid_s1 && fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
		end else begin
			if (push && !full) begin
				valid_s1 <= 1'b1;
			end else if (fifo_push) begin
				valid_s1 <= 1'b0;
			end
			if (fifo_push) begin
				phase_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			inc_s1 <= inc;
		end
	end

endmodule

@@ src/hchr_back.sv @@
// Back end: turns a queued hue into red, green and blue by the six-sector HSV rule.
`include "hue_cycle_hsv_to_rgb_macros.svh"

module hchr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fifo_empty,
	input  hchr_pkg::hue_t        fifo_data,
	output logic                  fifo_pop,
	input  hchr_pkg::color_cfg_t  color,
	output logic                  out_valid,
	input  logic                  pop,
	output hchr_pkg::result_t     result
);

	localparam int H     = hchr_pkg::HUE_BITS;
	localparam int CB    = hchr_pkg::COLOR_BITS;
	localparam int H3    = H + 3;
	localparam int AW    = H + 8;
	localparam int VCW   = 8 + CB;
	localparam int PW    = VCW + AW;
	localparam int XW    = PW - H;
	localparam int YW    = XW + 17;
	localparam int QEW   = YW - 32;
	localparam logic [VCW-1:0] COLOR_MAX = VCW'((64'd1 << CB) - 64'd1);
	localparam logic [AW-1:0]  FULL_A    = AW'(64'd255 << H);
	localparam logic [XW-1:0]  DEN       = XW'(64'd65025);
	localparam logic [16:0]    RECIP     = 17'((64'd1 << 32) / 64'd65025);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_ISSUE,
		S_DRAIN,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	typedef enum logic [1:0] {
		CH_V,
		CH_P,
		CH_Q,
		CH_T
	} chan_sel_t;

	state_t            state_q;
	chan_sel_t         idx_q;
	sector_t           sector_q;
	hchr_pkg::hue_t    hue_q;
	hchr_pkg::hue_t    f_q;
	logic [AW-1:0]     fs_q;
	logic [AW-1:0]     fcs_q;
	logic [VCW-1:0]    vc_q;
	logic              out_valid_q;
	hchr_pkg::result_t result_q;

	logic [H3-1:0]     hue6;
	logic [H:0]        f_comp;
	logic [AW-1:0]     a_sel;
	logic              load;

	logic              vld_s1;
	logic              vld_s2;
	chan_sel_t         idx_s1;
	chan_sel_t         idx_s2;
	logic [PW-1:0]     p_s1;
	logic [XW-1:0]     x_s2;
	logic [YW-1:0]     y_s2;

	logic [QEW-1:0]    q_est;
	logic [XW-1:0]     rem;
	logic [QEW-1:0]    quot;
	logic [CB-1:0]     val_q [4];

	logic [CB-1:0]     ch_r;
	logic [CB-1:0]     ch_g;
	logic [CB-1:0]     ch_b;

	assign fifo_pop  = (state_q == S_IDLE) && !fifo_empty;
	assign hue6      = H3'(fifo_data) * H3'(6);
	assign f_comp    = {1'b1, {H{1'b0}}} - {1'b0, f_q};
	assign load      = (state_q == S_OUT) && (!out_valid_q || pop);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	always_comb begin
		case (idx_q)
			CH_V:    a_sel = FULL_A;
			CH_P:    a_sel = AW'(AW'(8'd255 - color.saturation) << H);
			CH_Q:    a_sel = FULL_A - fs_q;
			CH_T:    a_sel = FULL_A - fcs_q;
			default: a_sel = FULL_A;
		endcase
	end

	always_comb begin
		q_est = y_s2[YW-1:32];
		rem   = x_s2 - XW'(XW'(q_est) * DEN);
		quot  = (rem >= DEN) ? q_est + 1'b1 : q_est;
	end

	always_comb begin
		case (sector_q)
			SEC_RED_YELLOW: begin
				ch_r = val_q[CH_V];
				ch_g = val_q[CH_T];
				ch_b = val_q[CH_P];
			end
			SEC_YELLOW_GREEN: begin
				ch_r = val_q[CH_Q];
				ch_g = val_q[CH_V];
				ch_b = val_q[CH_P];
			end
			SEC_GREEN_CYAN: begin
				ch_r = val_q[CH_P];
				ch_g = val_q[CH_V];
				ch_b = val_q[CH_T];
			end
			SEC_CYAN_BLUE: begin
				ch_r = val_q[CH_P];
				ch_g = val_q[CH_Q];
				ch_b = val_q[CH_V];
			end
			SEC_BLUE_MAGENTA: begin
				ch_r = val_q[CH_T];
				ch_g = val_q[CH_P];
				ch_b = val_q[CH_V];
			end
			default: begin
				ch_r = val_q[CH_V];
				ch_g = val_q[CH_P];
				ch_b = val_q[CH_Q];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= CH_V;
			sector_q    <= SEC_RED_YELLOW;
			hue_q       <= '0;
			f_q         <= '0;
			fs_q        <= '0;
			fcs_q       <= '0;
			vc_q        <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (pop && !load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!fifo_empty) begin
						hue_q    <= fifo_data;
						sector_q <= sector_t'(hue6[H3-1:H]);
						f_q      <= hue6[H-1:0];
						state_q  <= S_PREP;
					end
				end
				S_PREP: begin
					fs_q    <= AW'(AW'(f_q) * AW'(color.saturation));
					fcs_q   <= AW'((H + 9)'(f_comp) * (H + 9)'(color.saturation));
					vc_q    <= VCW'(color.brightness) * COLOR_MAX;
					idx_q   <= CH_V;
					state_q <= S_ISSUE;
				end
				S_ISSUE: begin
					idx_q <= chan_sel_t'(idx_q + 1'b1);
					if (idx_q == CH_T) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load) begin
						result_q.red   <= 8'(ch_r);
						result_q.green <= 8'(ch_g);
						result_q.blue  <= 8'(ch_b);
						result_q.hue   <= hchr_pkg::hue_to_q16(hue_q);
						out_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_ISSUE);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1   <= PW'(vc_q) * PW'(a_sel);
		idx_s1 <= idx_q;
		x_s2   <= p_s1[PW-1:H];
		y_s2   <= YW'(p_s1[PW-1:H]) * YW'(RECIP);
		idx_s2 <= idx_s1;
		if (vld_s2) begin
			val_q[idx_s2] <= CB'(quot);
		end
	end

	`HCHR_ASSERT(a_back_pop_idle, fifo_pop |-> state_q == S_IDLE, "Hue taken from the queue while busy.")
	`HCHR_ASSERT(a_back_quot_range, vld_s2 |-> quot <= QEW'(COLOR_MAX), "Channel value above full scale.")
	`HCHR_ASSERT(a_back_drained, state_q == S_OUT |-> !vld_s1 && !vld_s2, "Result formed before all channel values were written.")

endmodule

@@ src/hue_cycle_hsv_to_rgb.sv @@
// Top level of the hue cycle HSV to RGB color generator.
//
// Usage: each request on the input queue (push, full, elapsed) is a time tick.
// The block advances a wrapping hue phase by elapsed times speed, adds the hue
// offset and converts hue, saturation and brightness to red, green and blue.
// Results come out of a queue-like port: while empty is low, red, green, blue
// and hue show the oldest result, and it is taken when pop is high.
// Configuration is written through cfg_valid, cfg_ready, cfg_index and cfg_data:
// index 0 is speed, 1 is hue offset, 2 is saturation, 3 is brightness; other
// indexes are ignored. cfg_ready is always high.
// The back end converts one hue at a time; the limit on the result rate is the
// shared multiply and divide-by-constant pipeline of the back end, which forms
// four channel values one after another. A short queue lets ticks be accepted
// while the back end works and while a result waits to be taken.
// Reset clears the phase to zero, loads the default register values and empties
// every queue. When the receiver stalls, the finished result is held, then the
// queue fills and full rises.
module hue_cycle_hsv_to_rgb (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [hchr_pkg::ELAPSED_W-1:0]   elapsed,
	output logic                             empty,
	input  logic                             pop,
	output logic [hchr_pkg::CHAN_W-1:0]      red,
	output logic [hchr_pkg::CHAN_W-1:0]      green,
	output logic [hchr_pkg::CHAN_W-1:0]      blue,
	output logic [15:0]                      hue,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hchr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hchr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [hchr_pkg::SPEED_W-1:0]  speed_q;
	logic [hchr_pkg::OFFSET_W-1:0] hue_offset_q;
	hchr_pkg::color_cfg_t          color_q;

	logic                          fifo_push;
	logic                          fifo_full;
	logic                          fifo_pop;
	logic                          fifo_empty;
	hchr_pkg::hue_t                fifo_wdata;
	hchr_pkg::hue_t                fifo_rdata;
	logic                          out_valid;
	hchr_pkg::result_t             result;

	assign cfg_ready = 1'b1;
	assign empty     = !out_valid;
	assign red       = result.red;
	assign green     = result.green;
	assign blue      = result.blue;
	assign hue       = result.hue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q            <= hchr_pkg::SPEED_RESET;
			hue_offset_q       <= hchr_pkg::HUE_OFFSET_RESET;
			color_q.saturation <= hchr_pkg::SATURATION_RESET;
			color_q.brightness <= hchr_pkg::BRIGHTNESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hchr_pkg::CFG_SPEED:      speed_q            <= cfg_data[hchr_pkg::SPEED_W-1:0];
				hchr_pkg::CFG_HUE_OFFSET: hue_offset_q       <= cfg_data[hchr_pkg::OFFSET_W-1:0];
				hchr_pkg::CFG_SATURATION: color_q.saturation <= cfg_data[hchr_pkg::UNIT_W-1:0];
				hchr_pkg::CFG_BRIGHTNESS: color_q.brightness <= cfg_data[hchr_pkg::UNIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	hchr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.elapsed    (elapsed),
		.full       (full),
		.speed      (speed_q),
		.hue_offset (hue_offset_q),
		.fifo_push  (fifo_push),
		.fifo_data  (fifo_wdata),
		.fifo_full  (fifo_full)
	);

	hchr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.data_in  (fifo_wdata),
		.full     (fifo_full),
		.pop      (fifo_pop),
		.data_out (fifo_rdata),
		.empty    (fifo_empty)
	);

	hchr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_data  (fifo_rdata),
		.fifo_pop   (fifo_pop),
		.color      (color_q),
		.out_valid  (out_valid),
		.pop        (pop),
		.result     (result)
	);

endmodule
